/* design/eiec_pkg.sv */
// ----------------------------------------------------------------------------
// eiec_pkg
// Shared types and codes for the external interrupt edge controller.
// ----------------------------------------------------------------------------
package eiec_pkg;

    localparam int LINE_W = 16;   // register and line-vector width
    localparam int CODE_W = 4;    // width of one port code
    localparam int SEL_WORDS = 4; // port-select words
    localparam int PORT_W = 16;   // pins per port

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        REG_MASK = 4'd0,
        REG_RISE = 4'd1,
        REG_FALL = 4'd2,
        REG_SOFT = 4'd3,
        REG_PEND = 4'd4,
        REG_SEL0 = 4'd5,
        REG_SEL1 = 4'd6,
        REG_SEL2 = 4'd7,
        REG_SEL3 = 4'd8
    } reg_idx_t;

    // per-lane controls taken from the register bank
    typedef struct packed {
        logic rise_sel;
        logic fall_sel;
        logic unmask;
        logic prev;
    } lane_ctl_t;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic level;
        logic hit;
    } lane_out_t;

endpackage

/* design/external_interrupt_edge_controller_core.sv */
// ----------------------------------------------------------------------------
// external_interrupt_edge_controller_core
// Sixteen-line external interrupt controller with edge detection.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is a register read, a register write or a
//   pin-sample tick (kind in s_tuser). Every request yields exactly one
//   response on the m_ channel carrying read data, the interrupt request
//   lines (pending AND mask after the request) and an access-error flag.
//   Responses are registered. Throughput: one request per cycle while
//   s_tready is high; a lane per line samples its pin and detects edges
//   in parallel, and the merge stage folds the lane hits into the pending
//   register in the same cycle, so the register bank update sets the rate.
//   The response side has an output register plus one skid register: a
//   request is still accepted while a response waits, and s_tready drops
//   only once both are full, so no response is lost while m_tready is low.
//   Reset (aresetn low, synchronous) clears all bank registers: lines masked,
//   all lines on port A, no edges selected, pins last seen low; the first
//   tick after reset therefore sees a high pin as a rising edge.
// ----------------------------------------------------------------------------
module external_interrupt_edge_controller_core
    import eiec_pkg::*;
#(
    parameter int NUM_LINES = 16,
    parameter int NUM_PORTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: reg_index[3:0], write_data[19:4], port_pins[83:20], zero pad
    input  logic [87:0] s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: read_data[15:0], irq_lines[31:16]
    output logic [31:0] m_tdata,
    // m_tuser: access_error[0]
    output logic [0:0]  m_tuser
);

    // bits of existing lines, and of existing nibbles across the select words
    localparam logic [LINE_W-1:0] LINE_BITS =
        LINE_W'((17'(1) << NUM_LINES) - 17'(1));
    localparam logic [63:0] SEL_BITS =
        (64'(1) << (CODE_W * NUM_LINES)) - 64'(1);

    // request fields
    opcode_t           op;
    reg_idx_t          idx;
    logic [LINE_W-1:0] wdata;
    logic [63:0]       pins;
    logic [1:0]        sel_w;
    logic              accept;

    assign op     = opcode_t'(s_tuser);
    assign idx    = reg_idx_t'(s_tdata[3:0]);
    assign wdata  = s_tdata[19:4];
    assign pins   = s_tdata[83:20];
    assign sel_w  = 2'(s_tdata[3:0] - 4'(REG_SEL0));
    assign accept = s_tvalid & s_tready;

    // register bank
    logic [LINE_W-1:0] mask_reg, mask_next;
    logic [LINE_W-1:0] rise_reg, rise_next;
    logic [LINE_W-1:0] fall_reg, fall_next;
    logic [LINE_W-1:0] soft_reg, soft_next;
    logic [LINE_W-1:0] pend_reg, pend_next;
    logic [LINE_W-1:0] prev_reg, prev_next;
    logic [LINE_W-1:0] sel_reg  [SEL_WORDS];
    logic [LINE_W-1:0] sel_next [SEL_WORDS];

    // lane results
    logic [LINE_W-1:0] level_v;
    logic [LINE_W-1:0] hit_v;

    for (genvar i = 0; i < LINE_W; i++) begin : g_lane
        if (i < NUM_LINES) begin : g_on
            logic [NUM_PORTS-1:0] lane_pins;
            lane_ctl_t            ctl;
            lane_out_t            res;

            for (genvar p = 0; p < NUM_PORTS; p++) begin : g_pin
                assign lane_pins[p] = pins[PORT_W*p + i];
            end

            assign ctl.rise_sel = rise_reg[i];
            assign ctl.fall_sel = fall_reg[i];
            assign ctl.unmask   = mask_reg[i];
            assign ctl.prev     = prev_reg[i];

            eiec_lane #(
                .NUM_PORTS(NUM_PORTS)
            ) u_lane (
                .code (sel_reg[i/4][(i%4)*CODE_W +: CODE_W]),
                .pins (lane_pins),
                .ctl  (ctl),
                .res  (res)
            );

            assign level_v[i] = res.level;
            assign hit_v[i]   = res.hit;
        end else begin : g_off
            assign level_v[i] = 1'b0;
            assign hit_v[i]   = 1'b0;
        end
    end

    // merge stage and register access
    logic [LINE_W-1:0] rdata;
    logic              err;
    logic [LINE_W-1:0] fresh;

    always_comb begin
        mask_next = mask_reg;
        rise_next = rise_reg;
        fall_next = fall_reg;
        soft_next = soft_reg;
        pend_next = pend_reg;
        prev_next = prev_reg;
        for (int w = 0; w < SEL_WORDS; w++) begin
            sel_next[w] = sel_reg[w];
        end
        rdata = '0;
        err   = 1'b0;
        fresh = '0;
        case (op)
            OP_READ: begin
                case (idx)
                    REG_MASK: rdata = mask_reg;
                    REG_RISE: rdata = rise_reg;
                    REG_FALL: rdata = fall_reg;
                    REG_SOFT: rdata = soft_reg;
                    REG_PEND: rdata = pend_reg;
                    REG_SEL0, REG_SEL1, REG_SEL2, REG_SEL3: rdata = sel_reg[sel_w];
                    default:  err = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (idx)
                    REG_MASK: mask_next = wdata & LINE_BITS;
                    REG_RISE: rise_next = wdata & LINE_BITS;
                    REG_FALL: fall_next = wdata & LINE_BITS;
                    REG_SOFT: begin
                        // only a 0 -> 1 transition triggers
                        fresh     = wdata & LINE_BITS & ~soft_reg;
                        soft_next = soft_reg | fresh;
                        pend_next = pend_reg | (fresh & mask_reg);
                    end
                    REG_PEND: begin
                        // write 1 to clear, drops the soft trigger too
                        pend_next = pend_reg & ~wdata;
                        soft_next = soft_reg & ~wdata;
                    end
                    REG_SEL0, REG_SEL1, REG_SEL2, REG_SEL3: begin
                        sel_next[sel_w] = wdata & SEL_BITS[{sel_w, 4'b0000} +: LINE_W];
                    end
                    default: err = 1'b1;
                endcase
            end
            OP_TICK: begin
                // lane hits already carry the mask
                pend_next = pend_reg | hit_v;
                prev_next = level_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            rise_reg <= '0;
            fall_reg <= '0;
            soft_reg <= '0;
            pend_reg <= '0;
            prev_reg <= '0;
            for (int w = 0; w < SEL_WORDS; w++) begin
                sel_reg[w] <= '0;
            end
        end else if (accept) begin
            mask_reg <= mask_next;
            rise_reg <= rise_next;
            fall_reg <= fall_next;
            soft_reg <= soft_next;
            pend_reg <= pend_next;
            prev_reg <= prev_next;
            for (int w = 0; w < SEL_WORDS; w++) begin
                sel_reg[w] <= sel_next[w];
            end
        end
    end

    // response: output register plus skid register
    logic [32:0] resp;
    logic [32:0] out_reg;
    logic [32:0] skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        pop;

    assign resp     = {err, pend_next & mask_next, rdata};
    assign pop      = out_valid_reg & m_tready;
    assign s_tready = ~skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[31:0];
    assign m_tuser  = out_reg[32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // advance the parked response once the output drains
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= resp;
            end else begin
                out_reg <= resp;
            end
        end
    end

    // the skid register only fills behind a held output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a response while output is empty");

    // lines that do not exist never go pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg & ~LINE_BITS) == '0)
        else $error("pending bit set on a missing line");

    // an edge on a masked line is lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_TICK |=>
        ((pend_reg & ~$past(mask_reg)) == ($past(pend_reg) & ~$past(mask_reg))))
        else $error("tick set pending on a masked line");

    // a pending clear also drops the soft trigger
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_WRITE && idx == REG_PEND |=>
        ((soft_reg & $past(wdata)) == '0) && ((pend_reg & $past(wdata)) == '0))
        else $error("pending clear left bits set");

    // an erroneous access returns no data
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg[32] |-> out_reg[15:0] == '0)
        else $error("access error with nonzero read data");

endmodule

/* design/eiec_lane.sv */
// ----------------------------------------------------------------------------
// eiec_lane
// One line's pin select and edge detector.
// ----------------------------------------------------------------------------
module eiec_lane
    import eiec_pkg::*;
#(
    parameter int NUM_PORTS = 4
) (
    input  logic [CODE_W-1:0]    code,
    input  logic [NUM_PORTS-1:0] pins,
    input  lane_ctl_t            ctl,
    output lane_out_t            res
);

    logic level;

    // unsupported codes match no port and read low
    always_comb begin
        level = 1'b0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (code == CODE_W'(p)) begin
                level = pins[p];
            end
        end
    end

    assign res.level = level;
    assign res.hit   = ctl.unmask &
                       ((ctl.rise_sel & level & ~ctl.prev) |
                        (ctl.fall_sel & ~level & ctl.prev));

endmodule
